// ===== sv/dsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsrm_pkg
// Shared constants, command codes and controller/datapath interface types
// for the disjoint-set ring merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dsrm_pkg;

  localparam int MaxNodes = 1024;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CountW   = NodeW + 1;
  localparam int InDataW  = ((2 * NodeW + 7) / 8) * 8;
  localparam int OutDataW = ((NodeW + CountW + 7) / 8) * 8;
  localparam int UserW    = 2;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int OpW      = 4;

  // Register offsets (word index taken from paddr[2])
  localparam logic REG_NUM_NODES = 1'b0;

  // Sequencer step codes; the controller state carries these directly
  localparam logic [OpW-1:0] OP_IDLE   = 4'd0;
  localparam logic [OpW-1:0] OP_CLR    = 4'd1;
  localparam logic [OpW-1:0] OP_CHECK  = 4'd2;
  localparam logic [OpW-1:0] OP_RLB    = 4'd3;
  localparam logic [OpW-1:0] OP_RC1    = 4'd4;
  localparam logic [OpW-1:0] OP_RC2    = 4'd5;
  localparam logic [OpW-1:0] OP_CMP    = 4'd6;
  localparam logic [OpW-1:0] OP_WRD    = 4'd7;
  localparam logic [OpW-1:0] OP_WCHK   = 4'd8;
  localparam logic [OpW-1:0] OP_SP1    = 4'd9;
  localparam logic [OpW-1:0] OP_SP2    = 4'd10;
  localparam logic [OpW-1:0] OP_SP3    = 4'd11;
  localparam logic [OpW-1:0] OP_SP4    = 4'd12;
  localparam logic [OpW-1:0] OP_RERR   = 4'd13;
  localparam logic [OpW-1:0] OP_RSAME  = 4'd14;
  localparam logic [OpW-1:0] OP_RMERGE = 4'd15;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           take_in;
    logic           load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad;
    logic same;
    logic walk_go;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/disjoint_set_ring_merge_unit.sv =====
// ----------------------------------------------------------------------------
// disjoint_set_ring_merge_unit
// Disjoint-set table over a fixed node count with circular member rings,
// joining two nodes per request with union by size.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one join request (two node indices). m_axis returns one
//   result per request: merged/error flags, surviving label and new size.
//   The APB port holds num_nodes at offset 0; write it only while idle.
// Sequence, by controller step, from the transfer on s_axis to the result:
//   rejected request (equal nodes or index out of range): CHECK, RERR
//   already joined: CHECK, RLB, RC1, RC2, RSAME
//   merge: CHECK to RC2, CMP, WRD and WCHK repeated over the members of the
//   absorbed component, SP1 to SP4, RMERGE; the ring walk reads label and
//   next link of a member from their own tables in WRD and relabels it in WCHK.
//   One request is in flight at a time; s_axis_tready is high only idle.
// Reset: a clearing pass over the table rewrites every entry to its
//   singleton state; s_axis_tready stays low until it ends. APB writes are
//   taken throughout.
// Stall: a result waits in the output register while m_axis_tready is low;
//   the next request may already be taken, and its result then holds
//   until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_set_ring_merge_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [9:0] node_a, [19:10] node_b, rest zero
  input  wire logic [dsrm_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [9:0] survivor, [20:10] new_size, rest zero
  output logic      [dsrm_pkg::OutDataW-1:0]     m_axis_tdata,
  // [0] merged, [1] error
  output logic      [dsrm_pkg::UserW-1:0]        m_axis_tuser,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dsrm_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [dsrm_pkg::ApbDataW-1:0]     pwdata,
  output logic      [dsrm_pkg::ApbDataW-1:0]     prdata,
  output logic                                   pready
);

  localparam int NW = dsrm_pkg::NodeW;
  localparam int CW = dsrm_pkg::CountW;

  dsrm_pkg::cmd_t  cmd;
  dsrm_pkg::sts_t  sts;
  logic            out_merged, out_error;
  logic [NW-1:0]   out_survivor;
  logic [CW-1:0]   out_new_size;

  assign pready = 1'b1;

  dsrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsrm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_node_a    (s_axis_tdata[NW-1:0]),
    .in_node_b    (s_axis_tdata[2*NW-1:NW]),
    .cfg_we       (psel && penable && pwrite && pready),
    .cfg_addr     (paddr),
    .cfg_wdata    (pwdata),
    .cfg_rdata    (prdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_merged   (out_merged),
    .out_error    (out_error),
    .out_survivor (out_survivor),
    .out_new_size (out_new_size)
  );

  assign m_axis_tdata = {{(dsrm_pkg::OutDataW - NW - CW){1'b0}}, out_new_size, out_survivor};
  assign m_axis_tuser = {out_error, out_merged};

endmodule

`default_nettype wire

// ===== sv/dsrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsrm_ctrl
// Sequencer for the merge unit: clearing pass, lookup, ring walk, splice
// and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dsrm_pkg::sts_t sts,
  output dsrm_pkg::cmd_t     cmd
);

  logic [dsrm_pkg::OpW-1:0] state;
  logic [dsrm_pkg::OpW-1:0] state_next;
  logic                     in_result;

  assign in_ready  = (state == dsrm_pkg::OP_IDLE);
  assign in_result = (state == dsrm_pkg::OP_RERR) || (state == dsrm_pkg::OP_RSAME) ||
                     (state == dsrm_pkg::OP_RMERGE);

  assign cmd.op       = state;
  assign cmd.take_in  = in_ready && in_valid;
  assign cmd.load_out = in_result && sts.out_free;

  always_comb begin
    state_next = state;
    case (state)
      dsrm_pkg::OP_CLR: begin
        if (sts.clr_last) state_next = dsrm_pkg::OP_IDLE;
      end
      dsrm_pkg::OP_IDLE: begin
        if (in_valid) state_next = dsrm_pkg::OP_CHECK;
      end
      dsrm_pkg::OP_CHECK: begin
        state_next = sts.bad ? dsrm_pkg::OP_RERR : dsrm_pkg::OP_RLB;
      end
      dsrm_pkg::OP_RLB:  state_next = dsrm_pkg::OP_RC1;
      dsrm_pkg::OP_RC1:  state_next = dsrm_pkg::OP_RC2;
      dsrm_pkg::OP_RC2: begin
        state_next = sts.same ? dsrm_pkg::OP_RSAME : dsrm_pkg::OP_CMP;
      end
      dsrm_pkg::OP_CMP:  state_next = dsrm_pkg::OP_WRD;
      dsrm_pkg::OP_WRD:  state_next = dsrm_pkg::OP_WCHK;
      dsrm_pkg::OP_WCHK: begin
        // keep walking while the member still carries the absorbed label and the step count is below the table size
        state_next = sts.walk_go ? dsrm_pkg::OP_WRD : dsrm_pkg::OP_SP1;
      end
      dsrm_pkg::OP_SP1:  state_next = dsrm_pkg::OP_SP2;
      dsrm_pkg::OP_SP2:  state_next = dsrm_pkg::OP_SP3;
      dsrm_pkg::OP_SP3:  state_next = dsrm_pkg::OP_SP4;
      dsrm_pkg::OP_SP4:  state_next = dsrm_pkg::OP_RMERGE;
      dsrm_pkg::OP_RERR, dsrm_pkg::OP_RSAME, dsrm_pkg::OP_RMERGE: begin
        if (sts.out_free) state_next = dsrm_pkg::OP_IDLE;
      end
      default: state_next = dsrm_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsrm_pkg::OP_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dsrm_datapath.sv =====
// ----------------------------------------------------------------------------
// dsrm_datapath
// Label, ring and size tables, working registers, configuration register
// and the result register of the merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrm_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dsrm_pkg::cmd_t                    cmd,
  output dsrm_pkg::sts_t                         sts,
  input  wire logic [dsrm_pkg::NodeW-1:0]        in_node_a,
  input  wire logic [dsrm_pkg::NodeW-1:0]        in_node_b,
  input  wire logic                              cfg_we,
  input  wire logic [dsrm_pkg::ApbAddrW-1:0]     cfg_addr,
  input  wire logic [dsrm_pkg::ApbDataW-1:0]     cfg_wdata,
  output logic      [dsrm_pkg::ApbDataW-1:0]     cfg_rdata,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_merged,
  output logic                                   out_error,
  output logic      [dsrm_pkg::NodeW-1:0]        out_survivor,
  output logic      [dsrm_pkg::CountW-1:0]       out_new_size
);

  localparam int NW = dsrm_pkg::NodeW;
  localparam int CW = dsrm_pkg::CountW;
  localparam int N  = dsrm_pkg::MaxNodes;

  logic [NW-1:0] label_mem [N];
  logic [NW-1:0] next_mem  [N];
  logic [NW-1:0] prev_mem  [N];
  logic [CW-1:0] count_mem [N];

  logic          lab_we, nxt_we, prv_we, cnt_we;
  logic [NW-1:0] lab_waddr, nxt_waddr, prv_waddr, cnt_waddr;
  logic [NW-1:0] lab_wdata, nxt_wdata, prv_wdata;
  logic [CW-1:0] cnt_wdata;
  logic [NW-1:0] lab_raddr, nxt_raddr, prv_raddr, cnt_raddr;
  logic [NW-1:0] lab_q, nxt_q, prv_q;
  logic [CW-1:0] cnt_q;

  logic [NW-1:0] clr_idx;
  logic [CW-1:0] num_nodes;
  logic [NW-1:0] node_a, node_b, keep, gone, cur, p_keep, p_gone;
  logic [CW-1:0] cnt_keep, steps, new_sz, sum;
  logic          swap;

  assign sum  = cnt_keep + steps;
  assign swap = cnt_keep < cnt_q;

  assign sts.clr_last = (clr_idx == NW'(N - 1));
  assign sts.bad      = (node_a == node_b) || (CW'(node_a) >= num_nodes) ||
                        (CW'(node_b) >= num_nodes);
  assign sts.same     = (keep == gone);
  assign sts.walk_go  = (steps < CW'(N)) && (lab_q == gone);
  assign sts.out_free = !out_valid || out_ready;

  assign cfg_rdata = (cfg_addr[2] == dsrm_pkg::REG_NUM_NODES) ?
                     {{(dsrm_pkg::ApbDataW - CW){1'b0}}, num_nodes} : '0;

  // Table port decode per step
  always_comb begin
    lab_we = 1'b0; lab_waddr = '0; lab_wdata = '0; lab_raddr = '0;
    nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0; nxt_raddr = '0;
    prv_we = 1'b0; prv_waddr = '0; prv_wdata = '0; prv_raddr = '0;
    cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
    case (cmd.op)
      dsrm_pkg::OP_CLR: begin
        lab_we = 1'b1; lab_waddr = clr_idx; lab_wdata = clr_idx;
        nxt_we = 1'b1; nxt_waddr = clr_idx; nxt_wdata = clr_idx;
        prv_we = 1'b1; prv_waddr = clr_idx; prv_wdata = clr_idx;
        cnt_we = 1'b1; cnt_waddr = clr_idx; cnt_wdata = CW'(1);
      end
      dsrm_pkg::OP_CHECK: lab_raddr = node_a;
      dsrm_pkg::OP_RLB:   lab_raddr = node_b;
      dsrm_pkg::OP_RC1:   cnt_raddr = keep;
      dsrm_pkg::OP_RC2:   cnt_raddr = gone;
      dsrm_pkg::OP_WRD: begin
        lab_raddr = cur;
        nxt_raddr = cur;
      end
      dsrm_pkg::OP_WCHK: begin
        lab_we = sts.walk_go; lab_waddr = cur; lab_wdata = keep;
      end
      dsrm_pkg::OP_SP1: begin
        prv_raddr = keep;
        cnt_we = 1'b1; cnt_waddr = keep; cnt_wdata = sum;
      end
      dsrm_pkg::OP_SP2: begin
        prv_raddr = gone;
        cnt_we = 1'b1; cnt_waddr = gone; cnt_wdata = '0;
      end
      dsrm_pkg::OP_SP3: begin
        nxt_we = 1'b1; nxt_waddr = p_keep; nxt_wdata = gone;
        prv_we = 1'b1; prv_waddr = keep;   prv_wdata = prv_q;
      end
      dsrm_pkg::OP_SP4: begin
        nxt_we = 1'b1; nxt_waddr = p_gone; nxt_wdata = keep;
        prv_we = 1'b1; prv_waddr = gone;   prv_wdata = p_keep;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lab_we) label_mem[lab_waddr] <= lab_wdata;
    lab_q <= label_mem[lab_raddr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) next_mem[nxt_waddr] <= nxt_wdata;
    nxt_q <= next_mem[nxt_raddr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prev_mem[prv_waddr] <= prv_wdata;
    prv_q <= prev_mem[prv_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
    cnt_q <= count_mem[cnt_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      num_nodes <= CW'(N);
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == dsrm_pkg::OP_CLR) clr_idx <= clr_idx + NW'(1);
      if (cfg_we && (cfg_addr[2] == dsrm_pkg::REG_NUM_NODES)) begin
        num_nodes <= cfg_wdata[CW-1:0];
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      node_a <= in_node_a;
      node_b <= in_node_b;
    end
    case (cmd.op)
      dsrm_pkg::OP_RLB: keep <= lab_q;
      dsrm_pkg::OP_RC1: gone <= lab_q;
      dsrm_pkg::OP_RC2: cnt_keep <= cnt_q;
      dsrm_pkg::OP_CMP: begin
        // larger component keeps its label; tie goes to the first node
        if (swap) begin
          keep     <= gone;
          gone     <= keep;
          cnt_keep <= cnt_q;
          cur      <= keep;
        end else begin
          cur      <= gone;
        end
        steps <= '0;
      end
      dsrm_pkg::OP_WCHK: begin
        if (sts.walk_go) begin
          steps <= steps + CW'(1);
          cur   <= nxt_q;
        end
      end
      dsrm_pkg::OP_SP1: new_sz <= sum;
      dsrm_pkg::OP_SP2: p_keep <= prv_q;
      dsrm_pkg::OP_SP3: p_gone <= prv_q;
      default: ;
    endcase
    if (cmd.load_out) begin
      case (cmd.op)
        dsrm_pkg::OP_RSAME: begin
          out_merged   <= 1'b0;
          out_error    <= 1'b0;
          out_survivor <= keep;
          out_new_size <= cnt_keep;
        end
        dsrm_pkg::OP_RMERGE: begin
          out_merged   <= 1'b1;
          out_error    <= 1'b0;
          out_survivor <= keep;
          out_new_size <= new_sz;
        end
        default: begin
          out_merged   <= 1'b0;
          out_error    <= 1'b1;
          out_survivor <= '0;
          out_new_size <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/dsrm_checker.sv =====
// ----------------------------------------------------------------------------
// dsrm_checker
// Port-level checks of the merge unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrm_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [dsrm_pkg::OutDataW-1:0]     m_axis_tdata,
  input wire logic [dsrm_pkg::UserW-1:0]        m_axis_tuser
);

  localparam int NW = dsrm_pkg::NodeW;
  localparam int CW = dsrm_pkg::CountW;

  // clearing pass blocks requests right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request accepted during clearing pass");

  // one request in flight: a transfer closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (!m_axis_tuser[0] && (m_axis_tdata == '0)))
    else $error("rejected request carries data");

  // a merge joins two nonempty components and never exceeds the table
  a_merge_size: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      ((m_axis_tdata[NW+CW-1:NW] >= CW'(2)) &&
       (m_axis_tdata[NW+CW-1:NW] <= CW'(dsrm_pkg::MaxNodes))))
    else $error("merged size out of range");

endmodule

bind disjoint_set_ring_merge_unit dsrm_checker u_dsrm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives join requests into the disjoint-set ring merge unit and checks each
// result against a behavioral copy of the label table, member rings and sizes.
// Runs a directed part, then random phases over several node counts with
// varying amounts of source idling and sink backpressure.
// ----------------------------------------------------------------------------

module testbench;
  import dsrm_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 40;
  localparam int PhaseCount  = 9;
  localparam int MaxReports  = 50;

  typedef logic [NodeW-1:0]  node_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic   merged;
    logic   error;
    node_t  survivor;
    count_t new_size;
  } join_result_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [UserW-1:0]    m_axis_tuser;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Shadow copy of the block's table and register
  node_t  comp_label [MaxNodes];
  node_t  ring_fwd   [MaxNodes];
  node_t  ring_back  [MaxNodes];
  count_t comp_size  [MaxNodes];
  count_t node_limit;

  logic [InDataW-1:0] pending_joins[$];
  join_result_t       expected_results[$];

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    fail_count    = 0;
  int    cycle_count   = 0;
  node_t chain_node    = '0;

  always #5 clk = ~clk;

  disjoint_set_ring_merge_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Join two nodes in the shadow table and return the result the block owes
  function automatic join_result_t predict_join(node_t a, node_t b);
    join_result_t res;
    node_t        keep;
    node_t        gone;
    node_t        cur;
    node_t        tail_keep;
    node_t        tail_gone;
    int           steps;
    res = '0;
    if (a == b || a >= node_limit || b >= node_limit) begin
      res.error = 1'b1;
      return res;
    end
    keep = comp_label[a];
    gone = comp_label[b];
    if (keep == gone) begin
      res.survivor = keep;
      res.new_size = comp_size[keep];
      return res;
    end
    if (comp_size[keep] < comp_size[gone]) begin
      cur  = keep;
      keep = gone;
      gone = cur;
    end
    // relabel the absorbed ring member by member
    cur   = gone;
    steps = 0;
    while (steps < MaxNodes && comp_label[cur] == gone) begin
      comp_label[cur] = keep;
      steps++;
      cur = ring_fwd[cur];
    end
    comp_size[keep] = count_t'(comp_size[keep] + steps);
    comp_size[gone] = '0;
    tail_keep = ring_back[keep];
    tail_gone = ring_back[gone];
    ring_fwd[tail_keep] = gone;
    ring_fwd[tail_gone] = keep;
    ring_back[keep]     = tail_gone;
    ring_back[gone]     = tail_keep;
    res.merged   = 1'b1;
    res.survivor = keep;
    res.new_size = comp_size[keep];
    return res;
  endfunction

  function automatic logic [InDataW-1:0] random_join();
    int    roll;
    node_t a;
    node_t b;
    node_t t;
    roll = $urandom_range(99);
    if (roll < 8) begin
      a = node_t'($urandom_range(MaxNodes - 1));
      b = a;
    end else if (roll < 14 && node_limit < MaxNodes) begin
      a = node_t'($urandom_range(MaxNodes - 1, node_limit));
      b = node_t'($urandom_range(MaxNodes - 1));
      if ($urandom_range(1)) begin
        t = a;
        a = b;
        b = t;
      end
    end else begin
      // reuse the last node now and then so components grow in chains
      a = node_t'($urandom_range(node_limit - 1));
      b = (roll < 35) ? chain_node : node_t'($urandom_range(node_limit - 1));
      chain_node = a;
    end
    return InDataW'({b, a});
  endfunction

  task automatic push_join(int a, int b);
    pending_joins.push_back(InDataW'({node_t'(b), node_t'(a)}));
  endtask

  task automatic drain();
    while (pending_joins.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_node_limit(int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NUM_NODES, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    node_limit = count_t'(value);
    @(negedge clk);
  endtask

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 64;
        recv_idle_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_idle_pct = 64;
      end
      default: begin
        send_idle_pct = 8;
        recv_idle_pct = 8;
      end
    endcase
  endtask

  // Source: predict on each transfer, then load the next request or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_join(s_axis_tdata[NodeW-1:0],
                                                s_axis_tdata[2*NodeW-1:NodeW]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_joins.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= pending_joins.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink: check each result transfer against the oldest expectation
  always @(posedge clk) begin
    join_result_t got;
    join_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.merged   = m_axis_tuser[0];
        got.error    = m_axis_tuser[1];
        got.survivor = m_axis_tdata[NodeW-1:0];
        got.new_size = m_axis_tdata[NodeW+CountW-1:NodeW];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: unexpected result merged=%0d error=%0d survivor=%0d size=%0d",
                     $time, got.merged, got.error, got.survivor, got.new_size);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display({"%0t: result mismatch: expected merged=%0d error=%0d survivor=%0d ",
                        "size=%0d, got merged=%0d error=%0d survivor=%0d size=%0d"},
                       $time, want.merged, want.error, want.survivor, want.new_size,
                       got.merged, got.error, got.survivor, got.new_size);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int         plan_nodes [PhaseCount];
    int         plan_items [PhaseCount];
    idle_mode_t plan_mode  [PhaseCount];
    for (int i = 0; i < MaxNodes; i++) begin
      comp_label[i] = node_t'(i);
      ring_fwd[i]   = node_t'(i);
      ring_back[i]  = node_t'(i);
      comp_size[i]  = count_t'(1);
    end
    node_limit = count_t'(MaxNodes);

    plan_nodes = '{MaxNodes, MaxNodes - 1, 2, 600, MaxNodes, 0, MaxNodes, 3, MaxNodes};
    plan_items = '{300, 200, 40, 200, 250, 150, 200, 40, 70};
    plan_mode  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
                   IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
    plan_nodes[5] = $urandom_range(MaxNodes, 2);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: tie, repeat join, swap to larger side, equal nodes, top indices
    push_join(0, 1);
    push_join(1, 0);
    push_join(2, 0);
    push_join(3, 3);
    push_join(1023, 1022);
    push_join(1023, 0);
    push_join(5, 6);
    push_join(7, 8);
    push_join(5, 7);
    push_join(1022, 1023);
    push_join(0, 0);
    push_join(1023, 1023);
    push_join(682, 341);
    drain();

    // Out-of-range indices on either side
    write_node_limit(1000);
    push_join(1000, 4);
    push_join(4, 1000);
    push_join(999, 4);
    push_join(1023, 0);
    push_join(999, 999);
    drain();

    write_node_limit(2);
    push_join(0, 1);
    push_join(1, 2);
    push_join(0, 2);
    push_join(1, 0);
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      write_node_limit(plan_nodes[p]);
      set_idle(plan_mode[p]);
      for (int n = 0; n < plan_items[p]; n++)
        pending_joins.push_back(random_join());
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dsrm_pkg.sv
sv/dsrm_ctrl.sv
sv/dsrm_datapath.sv
sv/disjoint_set_ring_merge_unit.sv
sv/dsrm_checker.sv
bench/testbench.sv
